// ----- hdl/anb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// anb_pkg
// Shared types, constants and helpers of the Annex-B NAL unit splitter.
// ----------------------------------------------------------------------------
package anb_pkg;

  localparam logic [7:0] START_CODE_BYTE = 8'h01;
  localparam logic [7:0] ZERO_BYTE       = 8'h00;

  localparam logic [5:0] NAL_TYPE_VPS = 6'd32;
  localparam logic [5:0] NAL_TYPE_SPS = 6'd33;
  localparam logic [5:0] NAL_TYPE_PPS = 6'd34;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_VPS   = 2'd1,
    KIND_SPS   = 2'd2,
    KIND_PPS   = 2'd3
  } ps_kind_t;

  // One run of output bytes: optional head byte, a row of zeros, optional tail.
  typedef struct packed {
    logic       has_head;
    logic [7:0] head_byte;
    logic [2:0] zeros;
    logic       has_tail;
    logic [7:0] tail_byte;
    logic       close;
    logic       first;
    logic [5:0] utype;
    ps_kind_t   kind;
  } burst_t;

  typedef struct packed {
    logic       in_unit;
    logic [1:0] pending;
  } scan_status_t;

  typedef struct packed {
    logic [FIFO_AW:0] count;
    logic             full;
    logic             empty;
  } fifo_status_t;

  function automatic ps_kind_t kind_of(input logic [5:0] t);
    ps_kind_t k;
    case (t)
      NAL_TYPE_VPS: k = KIND_VPS;
      NAL_TYPE_SPS: k = KIND_SPS;
      NAL_TYPE_PPS: k = KIND_PPS;
      default:      k = KIND_OTHER;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] burst_len(input burst_t b);
    return {2'b00, b.has_head} + b.zeros + {2'b00, b.has_tail};
  endfunction

endpackage
`default_nettype wire

// ----- hdl/anb_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// anb_in_if
// Input byte channel: one Annex-B byte and its end-of-buffer flag.
// ----------------------------------------------------------------------------
interface anb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface
`default_nettype wire

// ----- hdl/anb_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// anb_out_if
// Result channel: one NAL content byte with its unit tags.
// ----------------------------------------------------------------------------
interface anb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [5:0] unit_type;
  logic [1:0] param_set_kind;
  logic       first_of_unit;
  logic       last_of_unit;

  modport source (output valid, output payload_byte, output unit_type,
                  output param_set_kind, output first_of_unit, output last_of_unit,
                  input ready);
  modport sink   (input valid, input payload_byte, input unit_type,
                  input param_set_kind, input first_of_unit, input last_of_unit,
                  output ready);
endinterface
`default_nettype wire

// ----- hdl/anb_scan.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// anb_scan
// Start-code scanner: tracks zeros and the held byte, builds at most one
// output burst per accepted byte.
// ----------------------------------------------------------------------------
module anb_scan
  import anb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         accept,
  input  wire logic [7:0]   data_byte,
  input  wire logic         end_of_buffer,
  output logic              push,
  output burst_t            burst,
  output scan_status_t      status
);

  logic       inside_r, inside_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic [7:0] held_value_r, held_value_nxt;
  logic [1:0] pend_r, pend_nxt;
  logic [5:0] type_r, type_nxt;
  logic       await_r, await_nxt;
  logic       emitted_r, emitted_nxt;

  logic       is_zero;
  logic       is_sc;
  logic       commit_any;
  logic       first_is_b;
  logic [5:0] type_now;

  always_comb begin
    is_zero    = (data_byte == ZERO_BYTE);
    is_sc      = (data_byte == START_CODE_BYTE) && (pend_r >= 2'd2);
    commit_any = inside_r && ((!is_zero && !is_sc) ||
                              (is_zero && ((pend_r == 2'd3) || end_of_buffer)));
    first_is_b = !is_zero && !is_sc && (pend_r == 2'd0);
    type_now   = (commit_any && await_r) ? (first_is_b ? data_byte[6:1] : 6'd0) : type_r;

    inside_nxt     = inside_r;
    held_valid_nxt = held_valid_r;
    held_value_nxt = held_value_r;
    pend_nxt       = pend_r;
    type_nxt       = type_r;
    await_nxt      = await_r;
    emitted_nxt    = emitted_r;

    burst           = '0;
    burst.head_byte = held_value_r;
    burst.has_head  = held_valid_r;
    burst.first     = !emitted_r;
    burst.utype     = type_now;
    burst.kind      = kind_of(type_now);

    if (is_zero) begin
      if (pend_r != 2'd3) begin
        pend_nxt = pend_r + 2'd1;
        if (end_of_buffer) begin
          burst.zeros = {1'b0, pend_r} + 3'd1;
          burst.close = 1'b1;
        end else begin
          burst.has_head = 1'b0;
        end
      end else if (end_of_buffer) begin
        burst.zeros = 3'd4;
        burst.close = 1'b1;
      end else if (inside_r) begin
        held_value_nxt = ZERO_BYTE;
        held_valid_nxt = 1'b1;
      end
    end else if (is_sc) begin
      burst.close    = 1'b1;
      inside_nxt     = 1'b1;
      held_valid_nxt = 1'b0;
      pend_nxt       = 2'd0;
      await_nxt      = 1'b1;
      emitted_nxt    = 1'b0;
    end else begin
      burst.zeros = {1'b0, pend_r};
      pend_nxt    = 2'd0;
      if (end_of_buffer) begin
        burst.has_tail  = 1'b1;
        burst.tail_byte = data_byte;
        burst.close     = 1'b1;
      end else if (inside_r) begin
        held_value_nxt = data_byte;
        held_valid_nxt = 1'b1;
      end
    end

    push = inside_r && (burst_len(burst) != 3'd0);

    if (commit_any) begin
      type_nxt  = type_now;
      await_nxt = 1'b0;
    end
    if (push && !is_sc) begin
      emitted_nxt = 1'b1;
    end

    if (end_of_buffer) begin
      inside_nxt     = 1'b0;
      held_valid_nxt = 1'b0;
      held_value_nxt = ZERO_BYTE;
      pend_nxt       = 2'd0;
      type_nxt       = 6'd0;
      await_nxt      = 1'b0;
      emitted_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r     <= 1'b0;
      held_valid_r <= 1'b0;
      pend_r       <= 2'd0;
      type_r       <= 6'd0;
      await_r      <= 1'b0;
      emitted_r    <= 1'b0;
    end else if (accept) begin
      inside_r     <= inside_nxt;
      held_valid_r <= held_valid_nxt;
      pend_r       <= pend_nxt;
      type_r       <= type_nxt;
      await_r      <= await_nxt;
      emitted_r    <= emitted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_value_r <= held_value_nxt;
    end
  end

  assign status.in_unit = inside_r;
  assign status.pending = pend_r;

endmodule
`default_nettype wire

// ----- hdl/anb_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// anb_fifo
// Small burst queue between the scanner and the byte serializer.
// ----------------------------------------------------------------------------
module anb_fifo
  import anb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire burst_t  wr_data,
  input  wire logic    pop,
  output burst_t       head,
  output fifo_status_t status
);

  burst_t             entry_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {{FIFO_AW{1'b0}}, push} - {{FIFO_AW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

  assign head         = entry_r[rd_ptr_r];
  assign status.count = count_r;
  assign status.full  = (count_r == FIFO_DEPTH[FIFO_AW:0]);
  assign status.empty = (count_r == '0);

endmodule
`default_nettype wire

// ----- hdl/anb_ser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// anb_ser
// Byte serializer: walks the head burst and drives one content byte per
// transfer.
// ----------------------------------------------------------------------------
module anb_ser
  import anb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire burst_t  head,
  input  wire logic    head_valid,
  output logic         pop,
  anb_out_if.source    out_chan
);

  logic [2:0] idx_r, idx_nxt;
  logic [2:0] last_idx;
  logic       at_last;
  logic       xfer;

  always_comb begin
    last_idx = burst_len(head) - 3'd1;
    at_last  = (idx_r == last_idx);
    xfer     = head_valid && out_chan.ready;
    pop      = xfer && at_last;
    idx_nxt  = idx_r;
    if (xfer) begin
      idx_nxt = at_last ? 3'd0 : idx_r + 3'd1;
    end

    if (head.has_head && (idx_r == 3'd0)) begin
      out_chan.payload_byte = head.head_byte;
    end else if (head.has_tail && at_last) begin
      out_chan.payload_byte = head.tail_byte;
    end else begin
      out_chan.payload_byte = ZERO_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  assign out_chan.valid          = head_valid;
  assign out_chan.unit_type      = head.utype;
  assign out_chan.param_set_kind = head.kind;
  assign out_chan.first_of_unit  = head.first && (idx_r == 3'd0);
  assign out_chan.last_of_unit   = head.close && at_last;

endmodule
`default_nettype wire

// ----- hdl/annexb_nal_splitter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// annexb_nal_splitter
// Annex-B start-code NAL unit splitter for H.265 byte streams.
// ----------------------------------------------------------------------------
// One byte is taken per clock while the buffer has room; each content byte
// leaves with its NAL type, parameter-set class and first/last flags. Every
// accepted byte is scanned in the same cycle and may release a burst of up to
// five content bytes (held byte, pending zeros, final byte at end of buffer);
// bursts queue in a four-entry buffer and drain at one byte per clock while
// the output is ready, so the input stalls only while that buffer is full.
// Each burst leaves from the buffer head. No clearing pass follows reset.
module annexb_nal_splitter
  import anb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  anb_in_if.sink    in_chan,
  anb_out_if.source out_chan
);

  logic         in_accept;
  logic         push;
  logic         pop;
  burst_t       burst;
  burst_t       head;
  scan_status_t scan_st;
  fifo_status_t fifo_st;

  assign in_chan.ready = !fifo_st.full;
  assign in_accept     = in_chan.valid && in_chan.ready;

  anb_scan u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .data_byte     (in_chan.data_byte),
    .end_of_buffer (in_chan.end_of_buffer),
    .push          (push),
    .burst         (burst),
    .status        (scan_st)
  );

  anb_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push && in_accept),
    .wr_data (burst),
    .pop     (pop),
    .head    (head),
    .status  (fifo_st)
  );

  anb_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (!fifo_st.empty),
    .pop        (pop),
    .out_chan   (out_chan)
  );

  a_eob_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_chan.end_of_buffer |=> !scan_st.in_unit && (scan_st.pending == 2'd0))
    else $error("scan state not cleared after end of buffer");

  a_sc_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !in_chan.end_of_buffer && (in_chan.data_byte == START_CODE_BYTE) &&
    (scan_st.pending >= 2'd2) |=> scan_st.in_unit)
    else $error("start code did not open a unit");

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_st.count <= FIFO_DEPTH[FIFO_AW:0])
    else $error("burst queue overflow");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !fifo_st.empty && out_chan.valid)
    else $error("burst popped from empty queue");

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Annex-B NAL unit splitter.
// ----------------------------------------------------------------------------
// Drives Annex-B byte buffers into the splitter and predicts every NAL content
// byte it should emit: type, parameter-set class and first/last flags. Two
// short directed buffers cover junk before the first start code, lone 01
// bytes, long zero runs, empty units and end of buffer outside a unit and on
// a start code. Random buffers of start codes and units with random content
// follow. Both sides throttle at random, and once the output is held off long
// enough for the splitter to fill up and stall its input.
// ----------------------------------------------------------------------------
module testbench
  import anb_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 120;
  localparam int HOLD_CYCLES    = 48;

  typedef struct packed {
    logic [7:0] payload;
    logic [5:0] utype;
    ps_kind_t   kind;
    logic       first;
    logic       last;
  } content_t;

  class nal_content_tracker;
    content_t   expected_bytes[$];
    int         errors;
    bit         in_unit;
    bit         held_ok;
    bit         need_first;
    bit         sent_any;
    logic [7:0] held_byte;
    logic [1:0] zero_run;
    logic [5:0] cur_type;

    function new();
      errors = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      in_unit    = 0;
      held_ok    = 0;
      need_first = 0;
      sent_any   = 0;
      held_byte  = '0;
      zero_run   = '0;
      cur_type   = '0;
    endfunction

    function ps_kind_t kind_for(logic [5:0] t);
      if (t == NAL_TYPE_VPS) return KIND_VPS;
      if (t == NAL_TYPE_SPS) return KIND_SPS;
      if (t == NAL_TYPE_PPS) return KIND_PPS;
      return KIND_OTHER;
    endfunction

    function void release_held(bit last);
      content_t c;
      if (!held_ok) return;
      c.payload = held_byte;
      c.utype   = cur_type;
      c.kind    = kind_for(cur_type);
      c.first   = !sent_any;
      c.last    = last;
      expected_bytes = {expected_bytes, c};
      sent_any = 1;
      held_ok  = 0;
    endfunction

    function void commit(logic [7:0] b);
      if (!in_unit) return;
      if (need_first) begin
        cur_type   = b[6:1];
        need_first = 0;
      end
      release_held(1'b0);
      held_byte = b;
      held_ok   = 1;
    endfunction

    function void flush_zeros();
      repeat (zero_run) commit(ZERO_BYTE);
      zero_run = '0;
    endfunction

    function void take_stream_byte(logic [7:0] b, logic eob);
      if (b == ZERO_BYTE) begin
        if (zero_run < 2'd3) zero_run++;
        else commit(ZERO_BYTE);
      end else if (b == START_CODE_BYTE && zero_run >= 2'd2) begin
        if (in_unit) release_held(1'b1);
        in_unit    = 1;
        held_ok    = 0;
        zero_run   = '0;
        need_first = 1;
        sent_any   = 0;
      end else begin
        flush_zeros();
        commit(b);
      end
      if (eob) begin
        if (in_unit) begin
          flush_zeros();
          release_held(1'b1);
        end
        clear_scan();
      end
    endfunction

    function void compare_content_byte(content_t got);
      content_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte: expected none, ", $time,
                 "got %h type %0d kind %0d first %b last %b",
                 got.payload, got.utype, got.kind, got.first, got.last);
        return;
      end
      want = expected_bytes.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: expected %h type %0d kind %0d first %b last %b, ",
                 $time, want.payload, want.utype, want.kind, want.first, want.last,
                 "got %h type %0d kind %0d first %b last %b",
                 got.payload, got.utype, got.kind, got.first, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  anb_in_if  in_chan();
  anb_out_if out_chan();

  annexb_nal_splitter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  nal_content_tracker tracker;
  int src_gap_pct;
  int sink_stall_pct;
  bit hold_request;
  int idle_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sample transfers and watch for a hang
  always @(posedge clk) begin : monitor
    content_t got;
    bit       moved;
    if (rst_n) begin
      moved = 0;
      if (in_chan.valid && in_chan.ready) begin
        tracker.take_stream_byte(in_chan.data_byte, in_chan.end_of_buffer);
        moved = 1;
      end
      if (out_chan.valid && out_chan.ready) begin
        got.payload = out_chan.payload_byte;
        got.utype   = out_chan.unit_type;
        got.kind    = ps_kind_t'(out_chan.param_set_kind);
        got.first   = out_chan.first_of_unit;
        got.last    = out_chan.last_of_unit;
        tracker.compare_content_byte(got);
        moved = 1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // output side: random stalls, one long hold-off on request
  initial begin : sink_side
    bit hold_done;
    hold_done = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1;
      end
      out_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic send_stream_byte(logic [7:0] b, logic eob);
    while ($urandom_range(99) < src_gap_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.data_byte     <= b;
    in_chan.end_of_buffer <= eob;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(7))
      0, 1:    return ZERO_BYTE;
      2:       return START_CODE_BYTE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] unit_header();
    logic [5:0] t;
    case ($urandom_range(3))
      0:       t = NAL_TYPE_VPS;
      1:       t = NAL_TYPE_SPS;
      2:       t = NAL_TYPE_PPS;
      default: t = 6'($urandom_range(63));
    endcase
    return {1'($urandom_range(1)), t, 1'($urandom_range(1))};
  endfunction

  // build one buffer, send it and report how many bytes follow its leading junk
  task automatic send_random_buffer(output int useful);
    logic [7:0] stream_q[$];
    int         junk;
    int         len;
    junk = 0;
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(1, 8)) stream_q = {stream_q, noise_byte()};
      junk = stream_q.size();
    end else begin
      repeat ($urandom_range(2)) stream_q = {stream_q, 8'($urandom_range(2, 255))};
      junk = stream_q.size();
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(5) == 0)
          repeat ($urandom_range(1, 3)) stream_q = {stream_q, ZERO_BYTE};
        if ($urandom_range(1)) stream_q = {stream_q, ZERO_BYTE};
        stream_q = {stream_q, ZERO_BYTE, ZERO_BYTE, START_CODE_BYTE};
        len = $urandom_range(6);
        if (len != 0) begin
          stream_q = {stream_q, unit_header()};
          repeat (len - 1) stream_q = {stream_q, noise_byte()};
        end
      end
    end
    foreach (stream_q[i]) send_stream_byte(stream_q[i], i == stream_q.size() - 1);
    useful = stream_q.size() - junk;
  endtask

  task automatic send_directed();
    // {end_of_buffer, byte}
    logic [8:0] steps[$];
    steps = '{9'h0ff, 9'h001, 9'h100,
              9'h000, 9'h000, 9'h001, 9'h040, 9'h000, 9'h001,
              9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h001,
              9'h000, 9'h000, 9'h001, 9'h042,
              9'h000, 9'h000, 9'h001, 9'h044, 9'h0fe,
              9'h000, 9'h000, 9'h101};
    foreach (steps[i]) send_stream_byte(steps[i][7:0], steps[i][8]);
  endtask

  initial begin : stimulus
    int sent;
    int chunk;
    tracker      = new();
    idle_cycles  = 0;
    hold_request = 0;
    src_gap_pct    = 24;
    sink_stall_pct = 61;
    rst_n                 <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.data_byte     <= '0;
    in_chan.end_of_buffer <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_directed();
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if (sent >= 2 * RANDOM_BYTES / 3) begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        hold_request   = 1;
      end else if (sent >= RANDOM_BYTES / 3) begin
        src_gap_pct    = 61;
        sink_stall_pct = 24;
      end
      send_random_buffer(chunk);
      sent += chunk;
    end
    in_chan.valid <= 1'b0;

    while (tracker.expected_bytes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
